### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks on aclk, masked while aresetn is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define U8_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/u8tce_pkg.sv
// ---------------------------------------------------------------------------
// u8tce_pkg
// shared types, constants and the emoji range check of the token estimator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8tce_pkg;

    localparam int unsigned CP_WIDTH    = 21;
    localparam int unsigned OUT_WIDTH   = 32;
    localparam int unsigned EXTRA_WIDTH = 4;

    // what one byte does to the open word run
    typedef enum logic [1:0] {
        RK_NONE  = 2'd0,
        RK_WORD  = 2'd1,
        RK_SPACE = 2'd2,
        RK_FLUSH = 2'd3
    } run_kind_t;

    // decoder to counter: run action plus small fixed token weight
    typedef struct packed {
        run_kind_t               kind;
        logic [EXTRA_WIDTH-1:0]  extra;
    } dec_t;

    // emoji ranges (weight 3)
    localparam logic [CP_WIDTH-1:0] EMO_FACE_LO   = 21'h1F600;
    localparam logic [CP_WIDTH-1:0] EMO_FACE_HI   = 21'h1F64F;
    localparam logic [CP_WIDTH-1:0] EMO_SYMB_LO   = 21'h1F300;
    localparam logic [CP_WIDTH-1:0] EMO_SYMB_HI   = 21'h1F5FF;
    localparam logic [CP_WIDTH-1:0] EMO_TRAN_LO   = 21'h1F680;
    localparam logic [CP_WIDTH-1:0] EMO_TRAN_HI   = 21'h1F6FF;
    localparam logic [CP_WIDTH-1:0] EMO_SUPP_LO   = 21'h1F900;
    localparam logic [CP_WIDTH-1:0] EMO_SUPP_HI   = 21'h1FAFF;
    localparam logic [CP_WIDTH-1:0] EMO_MISC_LO   = 21'h02600;
    localparam logic [CP_WIDTH-1:0] EMO_MISC_HI   = 21'h027BF;
    localparam logic [CP_WIDTH-1:0] EMO_VSEL_LO   = 21'h0FE00;
    localparam logic [CP_WIDTH-1:0] EMO_VSEL_HI   = 21'h0FE0F;
    localparam logic [CP_WIDTH-1:0] EMO_MAHJ_LO   = 21'h1F000;
    localparam logic [CP_WIDTH-1:0] EMO_MAHJ_HI   = 21'h1F02F;
    localparam logic [CP_WIDTH-1:0] EMO_CARD_LO   = 21'h1F0A0;
    localparam logic [CP_WIDTH-1:0] EMO_CARD_HI   = 21'h1F0FF;
    localparam logic [CP_WIDTH-1:0] EMO_ZWJ       = 21'h0200D;

    function automatic logic is_emoji(input logic [CP_WIDTH-1:0] cp);
        return (cp >= EMO_FACE_LO && cp <= EMO_FACE_HI) ||
               (cp >= EMO_SYMB_LO && cp <= EMO_SYMB_HI) ||
               (cp >= EMO_TRAN_LO && cp <= EMO_TRAN_HI) ||
               (cp >= EMO_SUPP_LO && cp <= EMO_SUPP_HI) ||
               (cp >= EMO_MISC_LO && cp <= EMO_MISC_HI) ||
               (cp >= EMO_VSEL_LO && cp <= EMO_VSEL_HI) ||
               (cp >= EMO_MAHJ_LO && cp <= EMO_MAHJ_HI) ||
               (cp >= EMO_CARD_LO && cp <= EMO_CARD_HI) ||
               (cp == EMO_ZWJ);
    endfunction

endpackage

### rtl/core/u8tce_decoder.sv
// ---------------------------------------------------------------------------
// u8tce_decoder
// utf-8 sequence tracker: classifies each byte and gives its run action
// and fixed token weight, holding the state of an unfinished sequence
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8tce_decoder
    import u8tce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  byte_in,
    input  logic        last_in,
    output dec_t        dec
);

    logic [1:0]          pend_reg, pend_next;
    logic [1:0]          expect_reg, expect_next;
    logic [CP_WIDTH-1:0] cp_reg, cp_next;
    logic [7:0]          lead_reg, lead_next;

    logic [7:0]          lo_bound;
    logic [7:0]          hi_bound;
    logic                fits;
    logic                is_word;
    logic [CP_WIDTH-1:0] cp_cont;

    // allowed range of the next continuation byte
    always_comb begin
        lo_bound = 8'h80;
        hi_bound = 8'hBF;
        if (pend_reg == 2'd1) begin
            unique case (lead_reg)
                8'hE0:   lo_bound = 8'hA0;
                8'hED:   hi_bound = 8'h9F;
                8'hF0:   lo_bound = 8'h90;
                8'hF4:   hi_bound = 8'h8F;
                default: ;
            endcase
        end
    end

    assign fits    = (pend_reg != 2'd0) && (byte_in >= lo_bound) && (byte_in <= hi_bound);
    assign cp_cont = {cp_reg[CP_WIDTH-7:0], byte_in[5:0]};
    assign is_word = (byte_in >= 8'h61 && byte_in <= 8'h7A) ||
                     (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
                     (byte_in >= 8'h30 && byte_in <= 8'h39) ||
                     (byte_in == 8'h5F) || (byte_in == 8'h27);

    // byte classification and sequence state update
    always_comb begin
        pend_next   = pend_reg;
        expect_next = expect_reg;
        cp_next     = cp_reg;
        lead_next   = lead_reg;
        dec.kind    = RK_NONE;
        dec.extra   = '0;
        if (fits) begin
            // continuation byte extends the pending sequence
            pend_next   = pend_reg + 2'd1;
            expect_next = expect_reg - 2'd1;
            cp_next     = cp_cont;
            if (expect_reg == 2'd1) begin
                dec.extra   = is_emoji(cp_cont) ? EXTRA_WIDTH'(3) : EXTRA_WIDTH'(2);
                pend_next   = 2'd0;
                expect_next = 2'd0;
                cp_next     = '0;
                lead_next   = '0;
            end
        end else begin
            // no continuation: two per held byte of a broken sequence, then the byte starts afresh
            dec.extra   = EXTRA_WIDTH'({pend_reg, 1'b0});
            pend_next   = 2'd0;
            expect_next = 2'd0;
            cp_next     = '0;
            lead_next   = '0;
            if (!byte_in[7]) begin
                if (is_word) begin
                    dec.kind = RK_WORD;
                end else if (byte_in == 8'h20 || byte_in == 8'h09) begin
                    dec.kind = RK_SPACE;
                end else begin
                    dec.kind  = RK_FLUSH;
                    dec.extra = dec.extra + EXTRA_WIDTH'(1);
                end
            end else begin
                dec.kind = RK_FLUSH;
                if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
                    pend_next   = 2'd1;
                    expect_next = 2'd1;
                    cp_next     = CP_WIDTH'(byte_in[4:0]);
                    lead_next   = byte_in;
                end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
                    pend_next   = 2'd1;
                    expect_next = 2'd2;
                    cp_next     = CP_WIDTH'(byte_in[3:0]);
                    lead_next   = byte_in;
                end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
                    pend_next   = 2'd1;
                    expect_next = 2'd3;
                    cp_next     = CP_WIDTH'(byte_in[2:0]);
                    lead_next   = byte_in;
                end else begin
                    dec.extra = dec.extra + EXTRA_WIDTH'(2);
                end
            end
        end
        // truncated sequence at end of text
        if (last_in) begin
            dec.extra   = dec.extra + EXTRA_WIDTH'({pend_next, 1'b0});
            pend_next   = 2'd0;
            expect_next = 2'd0;
            cp_next     = '0;
            lead_next   = '0;
        end
    end

    // sequence state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 2'd0;
            expect_reg <= 2'd0;
            cp_reg     <= '0;
            lead_reg   <= '0;
        end else if (fire) begin
            pend_reg   <= pend_next;
            expect_reg <= expect_next;
            cp_reg     <= cp_next;
            lead_reg   <= lead_next;
        end
    end

endmodule

### rtl/core/u8tce_counter.sv
// ---------------------------------------------------------------------------
// u8tce_counter
// word run length and saturating token total, final count at end of text
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8tce_counter
    import u8tce_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic                  last_in,
    input  dec_t                  dec,
    output logic [OUT_WIDTH-1:0]  count_out
);

    logic [COUNT_WIDTH-1:0] run_reg, run_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] run_inc;
    logic [COUNT_WIDTH-1:0] flush_val;
    logic [COUNT_WIDTH-1:0] ceil_val;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] total_sat;
    logic [OUT_WIDTH-1:0]   clipped;

    assign run_inc = (&run_reg) ? run_reg : run_reg + COUNT_WIDTH'(1);

    // run update and the run length to flush this beat
    always_comb begin
        run_next = run_reg;
        unique case (dec.kind)
            RK_WORD:  run_next = run_inc;
            RK_SPACE: run_next = (run_reg != '0) ? run_inc : run_reg;
            RK_FLUSH: run_next = '0;
            RK_NONE:  run_next = run_reg;
            default:  run_next = run_reg;
        endcase
        if (dec.kind == RK_FLUSH) begin
            flush_val = run_reg;
        end else if (last_in) begin
            flush_val = run_next;
        end else begin
            flush_val = '0;
        end
    end

    // ceil(run / 4) plus fixed weight, saturating add into total
    assign ceil_val  = {2'b00, flush_val[COUNT_WIDTH-1:2]} +
                       COUNT_WIDTH'(|flush_val[1:0]);
    assign sum       = {1'b0, total_reg} + (COUNT_WIDTH+1)'(ceil_val) +
                       (COUNT_WIDTH+1)'(dec.extra);
    assign total_sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

    // clip to the result width
    generate
        if (COUNT_WIDTH > OUT_WIDTH) begin : g_clip
            assign clipped = (|total_sat[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                   : total_sat[OUT_WIDTH-1:0];
        end else begin : g_ext
            assign clipped = OUT_WIDTH'(total_sat);
        end
    endgenerate

    // an empty estimate still counts as one token
    assign count_out  = (clipped == '0) ? OUT_WIDTH'(1) : clipped;
    assign total_next = last_in ? '0 : total_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            total_reg <= '0;
        end else if (fire) begin
            run_reg   <= last_in ? '0 : run_next;
            total_reg <= total_next;
        end
    end

endmodule

### rtl/core/utf8_token_count_estimator.sv
// ---------------------------------------------------------------------------
// utf8_token_count_estimator
// streaming utf-8 token estimate, one text byte per beat
// ---------------------------------------------------------------------------
// The block takes one byte per clock; s_tlast marks the final byte of a text,
// and one beat with the 32-bit estimate follows on the m_ side. A byte is
// registered on entry and then processed by the sequence decoder and the
// saturating counter; the estimate for an end-of-text byte is loaded into
// the result register, which drives m_tvalid. The only stall is on an
// end-of-text byte while the previous estimate still sits unclaimed in that register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_token_count_estimator
    import u8tce_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,   // last_byte
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_WIDTH-1:0]  m_tdata    // [31:0] token_count
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_WIDTH-1:0]  m_data_reg;
    logic                  out_free;
    logic                  proc_fire;
    dec_t                  dec;
    logic [OUT_WIDTH-1:0]  count_out;

    // handshake: an end-of-text beat waits only for a free result register
    assign out_free  = !m_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // sequence decoder
    u8tce_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .dec     (dec)
    );

    // run and total counter
    u8tce_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .last_in   (in_last_reg),
        .dec       (dec),
        .count_out (count_out)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc_fire && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_last_reg) begin
            m_data_reg <= count_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `U8_ASSERT_IMPL(a_count_nonzero, m_tvalid, m_tdata != '0, "zero token count offered")
    `U8_ASSERT_NEXT(a_result_loaded, proc_fire && in_last_reg, m_tvalid, "end of text gave no beat")
    `U8_ASSERT_IMPL(a_result_source, $rose(m_tvalid), $past(proc_fire && in_last_reg), "beat without end of text")
    `U8_ASSERT_IMPL(a_no_overwrite, proc_fire && in_last_reg && m_valid_reg, m_tready, "result overwritten")

endmodule
